@@ src/pbct_pkg.sv @@
`timescale 1ns / 1ps
package pbct_pkg;

  localparam int NUM_RATES_DEF = 8;
  localparam int CMD_W         = 3;
  localparam int IDX_IN_W      = 3;
  localparam int ALLOW_W       = 32;
  localparam int CREDIT_W      = 40;

  localparam logic [CMD_W-1:0] CMD_SET_ALLOW      = 3'd0;
  localparam logic [CMD_W-1:0] CMD_SET_REMAIN     = 3'd1;
  localparam logic [CMD_W-1:0] CMD_DEDUCT         = 3'd2;
  localparam logic [CMD_W-1:0] CMD_SET_ALLOW_REPL = 3'd3;
  localparam logic [CMD_W-1:0] CMD_REPL           = 3'd4;
  localparam logic [CMD_W-1:0] CMD_REPL_ALL       = 3'd5;
  localparam logic [CMD_W-1:0] CMD_QUERY          = 3'd6;
  localparam logic [CMD_W-1:0] CMD_MARK           = 3'd7;

  typedef struct packed {
    logic [CMD_W-1:0]    cmd;
    logic [IDX_IN_W-1:0] rate_index;
    logic [ALLOW_W-1:0]  amount;
  } in_word_t;

  typedef struct packed {
    logic [ALLOW_W-1:0]         allowance_bits;
    logic signed [CREDIT_W-1:0] remaining_bits;
    logic                       insufficient;
  } out_word_t;

  // One table entry as held in the memory.
  typedef struct packed {
    logic [ALLOW_W-1:0]         allowance;
    logic signed [CREDIT_W-1:0] remaining;
    logic                       flag;
  } entry_t;

endpackage

@@ src/pbct_mem.sv @@
`timescale 1ns / 1ps
module pbct_mem #(
  parameter int DEPTH = pbct_pkg::NUM_RATES_DEF,
  parameter int AW    = 3
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  pbct_pkg::entry_t wr_data,
  output pbct_pkg::entry_t rd_data
);
  import pbct_pkg::*;

  entry_t           mem [DEPTH];
  entry_t           q_r;
  logic             q_vld_r;
  logic [DEPTH-1:0] vld_r;

  // Entry storage; no reset, valid bits stand in for the cleared table.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      q_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      q_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        q_vld_r <= vld_r[rd_addr];
      end
    end
  end

  // Read an unwritten entry as zero.
  assign rd_data = q_vld_r ? q_r : '0;

endmodule

@@ src/pbct_alu.sv @@
`timescale 1ns / 1ps
module pbct_alu (
  input  logic [pbct_pkg::CMD_W-1:0]   cmd,
  input  logic [pbct_pkg::ALLOW_W-1:0] amount,
  input  pbct_pkg::entry_t             cur,
  output pbct_pkg::entry_t             nxt
);
  import pbct_pkg::*;

  localparam logic signed [CREDIT_W-1:0] CREDIT_MAX = {1'b0, {(CREDIT_W-1){1'b1}}};
  localparam logic signed [CREDIT_W-1:0] CREDIT_MIN = {1'b1, {(CREDIT_W-1){1'b0}}};

  logic [ALLOW_W-1:0]         addend;
  logic [CREDIT_W:0]          sum;
  logic signed [CREDIT_W-1:0] sat;

  // One shared adder: add allowance (or new allowance), or subtract the deduction.
  always_comb begin
    addend = (cmd == CMD_SET_ALLOW_REPL || cmd == CMD_DEDUCT) ? amount : cur.allowance;
    if (cmd == CMD_DEDUCT) begin
      sum = {cur.remaining[CREDIT_W-1], cur.remaining}
            - {{(CREDIT_W-ALLOW_W+1){1'b0}}, addend};
    end else begin
      sum = {cur.remaining[CREDIT_W-1], cur.remaining}
            + {{(CREDIT_W-ALLOW_W+1){1'b0}}, addend};
    end
    if (sum[CREDIT_W] != sum[CREDIT_W-1]) begin
      sat = sum[CREDIT_W] ? CREDIT_MIN : CREDIT_MAX;
    end else begin
      sat = sum[CREDIT_W-1:0];
    end
  end

  always_comb begin
    nxt = cur;
    case (cmd) inside
      CMD_SET_ALLOW: begin
        nxt.allowance = amount;
        nxt.flag      = (amount == '0);
      end
      CMD_SET_REMAIN: begin
        nxt.remaining = {{(CREDIT_W-ALLOW_W){1'b0}}, amount};
      end
      CMD_DEDUCT: begin
        nxt.remaining = sat;
        nxt.flag      = cur.flag | sat[CREDIT_W-1] | (sat == '0);
      end
      CMD_SET_ALLOW_REPL: begin
        nxt.allowance = amount;
        nxt.remaining = sat;
        nxt.flag      = (sat == '0);
      end
      CMD_REPL, CMD_REPL_ALL: begin
        nxt.remaining = sat;
        nxt.flag      = (sat == '0);
      end
      CMD_QUERY: begin
        nxt.flag = cur.flag | (cur.allowance == '0);
      end
      default: begin
        nxt.flag = 1'b1;
      end
    endcase
  end

endmodule

@@ src/per_rate_bit_credit_table.sv @@
`timescale 1ns / 1ps
// Sequence: a single-class command passes the read, modify-write and output steps before
//   its result word; an index beyond the table goes straight to the output step; replenish
//   all repeats the read and modify-write for every class before the output step.
// Flow: one command at a time through the read-modify-write of the entry memory; a new
//   command waits until the sequencer is idle, and a held result word keeps it busy.
// Reset: synchronous, active low; clears control state and per-entry valid bits.
module per_rate_bit_credit_table #(
  parameter int NUM_RATES = pbct_pkg::NUM_RATES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  pbct_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output pbct_pkg::out_word_t out_word
);
  import pbct_pkg::*;

  // Memory address width, and a width that holds both an address and the input index.
  localparam int AW = (NUM_RATES > 1) ? $clog2(NUM_RATES) : 1;
  localparam int XW = (AW > IDX_IN_W) ? AW : IDX_IN_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RD   = 2'd1;
  localparam logic [1:0] S_MOD  = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0]          state_r, state_nxt;
  logic [CMD_W-1:0]    cmd_r;
  logic [ALLOW_W-1:0]  amount_r;
  logic [XW-1:0]       idx_r;
  logic                idx_ok_r;
  logic [AW-1:0]       addr_r, addr_nxt;
  entry_t              res_r, res_nxt;
  logic                out_valid_r;
  out_word_t           out_word_r;

  logic                accept;
  logic [XW-1:0]       in_idx;
  logic                in_idx_ok;
  logic                sweep;
  logic                rd_en;
  logic                wr_en;
  logic                out_load;
  entry_t              rd_data;
  entry_t              upd;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign in_idx    = XW'(in_word.rate_index);
  assign in_idx_ok = ({1'b0, in_idx} < (XW+1)'(NUM_RATES));
  assign sweep     = (cmd_r == CMD_REPL_ALL);
  assign rd_en     = (state_r == S_RD);
  assign wr_en     = (state_r == S_MOD);
  assign out_load  = (state_r == S_OUT) && (!out_valid_r || !out_stall);

  pbct_mem #(
    .DEPTH (NUM_RATES),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (rd_en),
    .rd_addr (addr_r),
    .wr_en   (wr_en),
    .wr_addr (addr_r),
    .wr_data (upd),
    .rd_data (rd_data)
  );

  pbct_alu u_alu (
    .cmd    (cmd_r),
    .amount (amount_r),
    .cur    (rd_data),
    .nxt    (upd)
  );

  // Sequencer: read the entry, modify and write it back, then hand the
  // result to the output register. Replenish all walks every class in turn
  // and keeps the addressed class's updated entry as the result.
  always_comb begin
    state_nxt = state_r;
    addr_nxt  = addr_r;
    res_nxt   = res_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          res_nxt = '0;
          if (in_word.cmd == CMD_REPL_ALL) begin
            addr_nxt  = '0;
            state_nxt = S_RD;
          end else if (in_idx_ok) begin
            addr_nxt  = in_idx[AW-1:0];
            state_nxt = S_RD;
          end else begin
            // Index beyond the table: answer with an all-zero word.
            state_nxt = S_OUT;
          end
        end
      end
      S_RD: begin
        state_nxt = S_MOD;
      end
      S_MOD: begin
        if (!sweep) begin
          res_nxt   = upd;
          state_nxt = S_OUT;
        end else begin
          if (idx_ok_r && (XW'(addr_r) == idx_r)) begin
            res_nxt = upd;
          end
          if (addr_r == AW'(NUM_RATES - 1)) begin
            state_nxt = S_OUT;
          end else begin
            addr_nxt  = addr_r + 1'b1;
            state_nxt = S_RD;
          end
        end
      end
      S_OUT: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Hold command fields for the whole read-modify-write.
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r    <= in_word.cmd;
      amount_r <= in_word.amount;
      idx_r    <= in_idx;
      idx_ok_r <= in_idx_ok;
    end
    addr_r <= addr_nxt;
    res_r  <= res_nxt;
    if (out_load) begin
      out_word_r.allowance_bits <= res_r.allowance;
      out_word_r.remaining_bits <= res_r.remaining;
      out_word_r.insufficient   <= res_r.flag;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

`ifndef SYNTHESIS
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r != S_IDLE))
    else $error("command accepted but sequencer stayed idle");

  a_mod_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MOD) |-> ($past(state_r) == S_RD))
    else $error("write-back without a preceding memory read");

  a_addr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RD) |-> ({1'b0, addr_r} < (AW+1)'(NUM_RATES)))
    else $error("memory address beyond the table");

  a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_OUT))
    else $error("result word raised outside the output step");
`endif

endmodule
